[hdl/assert_macros.svh]
// Assertion macros shared by the packet slot FIFO RTL.
// Expects clk and arst_n in the including module's scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, expr) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) \
		else $error("assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

[hdl/psfdc_pkg.sv]
// Package for the packet slot FIFO: transaction payload types and mode codes.
// No dependencies.
package psfdc_pkg;

	localparam logic [1:0] MODE_PUSH_START = 2'd0;
	localparam logic [1:0] MODE_PUSH_BYTE  = 2'd1;
	localparam logic [1:0] MODE_POP_BYTE   = 2'd2;
	localparam logic [1:0] MODE_STATUS     = 2'd3;

	typedef struct packed {
		logic [1:0]  mode;
		logic [15:0] packet_length;
		logic [7:0]  data_byte;
	} in_item_t;

	typedef struct packed {
		logic        ok;
		logic [7:0]  out_byte;
		logic [10:0] head_length;
		logic        last_of_packet;
		logic [2:0]  fill_level;
		logic [31:0] drops;
	} out_item_t;

endpackage

[hdl/psfdc_ram.sv]
// Generic simple dual-port RAM, one write port and one registered read port.
// No dependencies.
module psfdc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

[hdl/packet_slot_fifo_with_drop_count.sv]
// Packet slot FIFO with drop counter, top level.
// Depends on psfdc_pkg, psfdc_ram and assert_macros.svh.
//
// Usage:
// - Input channel in_valid/in_ready/in_data carries one command transaction
//   (push_start, push_byte, pop_byte or status). Output channel
//   out_valid/out_ready/out_data returns exactly one result per command.
// - push_start, push_byte and status may follow each other every cycle while
//   the receiver does not stall. A pop_byte reads its slot length and data
//   byte from the registered read port of the slot memories, and the next
//   command waits until the pop has been resolved.
// - Each result passes a result stage and an output register: out_valid rises
//   when the result moves from the result stage into the output register.
// - Packet bytes live in a SLOT_COUNT*SLOT_BYTES byte RAM, slot lengths in a
//   SLOT_COUNT entry RAM; neither is cleared, only committed slots feed a result.
// - Reset clears slot pointers, offsets, the open push and the drop counter;
//   the block takes commands as soon as reset is released.
// - When the receiver stalls, one result waits in the output register and one
//   more in the result stage; after that in_ready drops until out_ready.
module packet_slot_fifo_with_drop_count #(
	parameter int SLOT_COUNT = 8,
	parameter int SLOT_BYTES = 1024
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  psfdc_pkg::in_item_t  in_data,
	output logic                 out_valid,
	input  logic                 out_ready,
	output psfdc_pkg::out_item_t out_data
);

`include "assert_macros.svh"

	localparam int SW = $clog2(SLOT_COUNT);
	localparam int LW = $clog2(SLOT_BYTES + 1);
	localparam int AW = $clog2(SLOT_COUNT * SLOT_BYTES);
	localparam logic [SW-1:0] LastSlot = SW'(SLOT_COUNT - 1);

	function automatic logic [SW-1:0] next_slot(input logic [SW-1:0] s);
		return (s == LastSlot) ? '0 : s + SW'(1);
	endfunction

	logic [SW-1:0] wr_slot_q, rd_slot_q;
	logic [31:0]   drop_q;
	logic [LW-1:0] fill_off_q, fill_len_q, drain_q;
	logic          filling_q;

	logic s1_valid_q, s1_pop_q, s1_ok_q;
	logic out_valid_q;
	psfdc_pkg::out_item_t out_q;

	logic in_acc, s1_adv;
	logic is_start, is_byte, is_pop;
	logic too_long, full, start_ok;
	logic len_we, byte_we;
	logic [LW-1:0] fill_inc, drain_inc;
	logic byte_done;
	logic [AW-1:0] byte_wr_addr, byte_rd_addr;
	logic [LW-1:0] len_rd;
	logic [7:0]    byte_rd;
	logic nonpop_ok;

	logic empty, pop_last, pop_free;
	logic [SW-1:0] rd_after;
	logic [SW:0]   lvl;
	psfdc_pkg::out_item_t res;

	assign s1_adv   = s1_valid_q && (!out_valid_q || out_ready);
	assign in_ready = !s1_valid_q || (s1_adv && !s1_pop_q);
	assign in_acc   = in_valid && in_ready;

	assign is_start = in_acc && (in_data.mode == psfdc_pkg::MODE_PUSH_START);
	assign is_byte  = in_acc && (in_data.mode == psfdc_pkg::MODE_PUSH_BYTE);
	assign is_pop   = in_acc && (in_data.mode == psfdc_pkg::MODE_POP_BYTE);

	assign too_long = in_data.packet_length > 16'(SLOT_BYTES);
	assign full     = next_slot(wr_slot_q) == rd_slot_q;
	assign start_ok = !too_long && !full;
	assign len_we   = is_start && start_ok;
	assign byte_we  = is_byte && filling_q;

	assign fill_inc  = fill_off_q + LW'(1);
	assign byte_done = fill_inc >= fill_len_q;

	assign byte_wr_addr = AW'(wr_slot_q) * AW'(SLOT_BYTES) + AW'(fill_off_q);
	assign byte_rd_addr = AW'(rd_slot_q) * AW'(SLOT_BYTES) + AW'(drain_q);

	always_comb begin
		case (in_data.mode)
			psfdc_pkg::MODE_PUSH_START: nonpop_ok = start_ok;
			psfdc_pkg::MODE_PUSH_BYTE:  nonpop_ok = filling_q;
			psfdc_pkg::MODE_STATUS:     nonpop_ok = 1'b1;
			default:                    nonpop_ok = 1'b0;
		endcase
	end

	psfdc_ram #(
		.WIDTH (LW),
		.DEPTH (SLOT_COUNT)
	) u_len_ram (
		.clk     (clk),
		.wr_en   (len_we),
		.wr_addr (wr_slot_q),
		.wr_data (LW'(in_data.packet_length)),
		.rd_en   (is_pop),
		.rd_addr (rd_slot_q),
		.rd_data (len_rd)
	);

	psfdc_ram #(
		.WIDTH (8),
		.DEPTH (SLOT_COUNT * SLOT_BYTES)
	) u_byte_ram (
		.clk     (clk),
		.wr_en   (byte_we),
		.wr_addr (byte_wr_addr),
		.wr_data (in_data.data_byte),
		.rd_en   (is_pop),
		.rd_addr (byte_rd_addr),
		.rd_data (byte_rd)
	);

	// pop resolution in the result stage
	assign empty     = rd_slot_q == wr_slot_q;
	assign drain_inc = drain_q + LW'(1);
	assign pop_last  = drain_inc >= len_rd;
	assign pop_free  = s1_pop_q && !empty && pop_last;
	assign rd_after  = pop_free ? next_slot(rd_slot_q) : rd_slot_q;

	always_comb begin
		if (wr_slot_q >= rd_after) begin
			lvl = {1'b0, wr_slot_q} - {1'b0, rd_after};
		end else begin
			lvl = {1'b0, wr_slot_q} + (SW+1)'(SLOT_COUNT) - {1'b0, rd_after};
		end
	end

	always_comb begin
		res            = '0;
		res.fill_level = 3'(lvl);
		res.drops      = drop_q;
		if (s1_pop_q) begin
			if (!empty) begin
				res.ok             = 1'b1;
				res.out_byte       = (len_rd != '0) ? byte_rd : 8'd0;
				res.head_length    = 11'(len_rd);
				res.last_of_packet = pop_last;
			end
		end else begin
			res.ok = s1_ok_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_slot_q  <= '0;
			rd_slot_q  <= '0;
			drop_q     <= '0;
			fill_off_q <= '0;
			fill_len_q <= '0;
			drain_q    <= '0;
			filling_q  <= 1'b0;
		end else begin
			if (is_start) begin
				fill_off_q <= '0;
				filling_q  <= start_ok && (in_data.packet_length != 16'd0);
				fill_len_q <= LW'(in_data.packet_length);
				if (!start_ok) begin
					drop_q <= drop_q + 32'd1;
				end else if (in_data.packet_length == 16'd0) begin
					wr_slot_q <= next_slot(wr_slot_q);
				end
			end
			if (byte_we) begin
				if (byte_done) begin
					fill_off_q <= '0;
					filling_q  <= 1'b0;
					wr_slot_q  <= next_slot(wr_slot_q);
				end else begin
					fill_off_q <= fill_inc;
				end
			end
			if (s1_adv && s1_pop_q && !empty) begin
				drain_q   <= pop_last ? '0 : drain_inc;
				rd_slot_q <= rd_after;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
			s1_pop_q   <= 1'b0;
			s1_ok_q    <= 1'b0;
		end else if (in_acc) begin
			s1_valid_q <= 1'b1;
			s1_pop_q   <= in_data.mode == psfdc_pkg::MODE_POP_BYTE;
			s1_ok_q    <= nonpop_ok;
		end else if (s1_adv) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_adv) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			out_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	`ASSERT_ALWAYS(a_pop_blocks_accept, !(in_acc && s1_valid_q && s1_pop_q))
	`ASSERT_ALWAYS(a_slots_in_range, (wr_slot_q <= LastSlot) && (rd_slot_q <= LastSlot))
	`ASSERT_ALWAYS(a_fill_below_len, !filling_q || (fill_off_q < fill_len_q))
	`ASSERT_ALWAYS(a_last_implies_ok, !out_valid_q || !out_q.last_of_packet || out_q.ok)
	`ASSERT_NEXT(a_drop_step, 1'b1, (drop_q == $past(drop_q)) || (drop_q == $past(drop_q) + 32'd1))

endmodule
